// ===== hdl/s0te_pkg.sv =====
// ----------------------------------------------------------------------------
// s0te_pkg
// Types and codes of the terminal-side S/T layer-1 activation machine.
// ----------------------------------------------------------------------------
package s0te_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int REG_W          = 16;
	localparam int IN_DATA_W      = 8;
	localparam int OUT_DATA_W     = 16;

	localparam logic [REG_W-1:0] T3_TICKS_RST    = 16'd7000;
	localparam logic [REG_W-1:0] ACT_DELAY_RST   = 16'd110;
	localparam logic [REG_W-1:0] DEACT_DELAY_RST = 16'd550;

	localparam logic [1:0] CFG_T3_TICKS    = 2'd0;
	localparam logic [1:0] CFG_ACT_DELAY   = 2'd1;
	localparam logic [1:0] CFG_DEACT_DELAY = 2'd2;

	localparam logic [3:0] EV_TICK       = 4'd0;
	localparam logic [3:0] EV_ACTIVATE   = 4'd1;
	localparam logic [3:0] EV_LINE_RESET = 4'd2;
	localparam logic [3:0] EV_DEACT_DONE = 4'd3;
	localparam logic [3:0] EV_LINE_DEACT = 4'd4;
	localparam logic [3:0] EV_POWERUP    = 4'd5;
	localparam logic [3:0] EV_RSYNC      = 4'd6;
	localparam logic [3:0] EV_INFO2      = 4'd7;
	localparam logic [3:0] EV_INFO4      = 4'd8;

	typedef enum logic [2:0] {
		ST_F2 = 3'd0,
		ST_F3 = 3'd1,
		ST_F4 = 3'd2,
		ST_F5 = 3'd3,
		ST_F6 = 3'd4,
		ST_F7 = 3'd5,
		ST_F8 = 3'd6
	} line_state_t;

	typedef enum logic [2:0] {
		HW_NONE       = 3'd0,
		HW_RESET_REQ  = 3'd1,
		HW_ENABLE_REQ = 3'd2,
		HW_INFO3_REQ  = 3'd3,
		HW_DEACT_RSP  = 3'd4
	} hw_req_t;

	typedef enum logic [1:0] {
		UP_NONE      = 2'd0,
		UP_ACT_CNF   = 2'd1,
		UP_ACT_IND   = 2'd2,
		UP_DEACT_IND = 2'd3
	} upper_msg_t;

	typedef enum logic [1:0] {
		TK_NONE  = 2'd0,
		TK_T3    = 2'd1,
		TK_ACT   = 2'd2,
		TK_DEACT = 2'd3
	} timer_kind_t;

	typedef struct packed {
		logic activating;
		logic activated;
		logic t3_running;
		logic act_timer;
		logic deact_timer;
	} flags_t;

endpackage

// ===== hdl/s0_te_activation_fsm_top.sv =====
// ----------------------------------------------------------------------------
// s0_te_activation_fsm_top
// Terminal-side S/T layer-1 activation machine with one shared event timer.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  one event
// m_*      out        m_tvalid/m_tready  state, requests and messages
// cfg_*    in         cfg_valid/ready    register index and 16-bit value
//
// One event is taken per cycle while the result register is not stalled; its result
// passes through the input register and then the result register before it is presented.
// The transition, the flag updates and the timer decrement happen in the same
// cycle that moves an event from the input register to the result register.
// A stalled result register holds the input register; nothing is lost.
// Reset loads the machine into F3 with all flags clear and the timer stopped.
// ----------------------------------------------------------------------------
module s0_te_activation_fsm_top
	import s0te_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [3:0] action, [4] frame_seen, [5] dchan_busy, [7:6] zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [2:0] line_state, [5:3] hw_request, [7:6] upper_msg, [8] pause_confirm,
	// [9] is_activated, [15:10] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [REG_W-1:0]      cfg_data
);

	localparam int CW = (TIMER_BITS > REG_W) ? TIMER_BITS : REG_W;
	localparam logic [CW-1:0] TMAX = CW'({TIMER_BITS{1'b1}});
	localparam logic [TIMER_BITS-1:0] TONE = TIMER_BITS'(1);

	logic [REG_W-1:0] t3_ticks_q, act_delay_q, deact_delay_q;

	logic                 valid_s1;
	logic [3:0]           action_s1;
	logic                 frame_s1, busy_s1;

	line_state_t          state_q, state_d;
	flags_t               flags_q, flags_d;
	logic [TIMER_BITS-1:0] count_q, count_d;
	logic                 pending_q, pending_d;
	timer_kind_t          kind_q, kind_d;

	hw_req_t              hw_d;
	upper_msg_t           up_d;
	logic                 pause_d;

	logic                 advance;
	logic                 in_range, early, fire, act_ok, t3_ok, deact_ok;
	logic [TIMER_BITS-1:0] load_t3, load_act, load_deact;

	function automatic logic [TIMER_BITS-1:0] cap(input logic [REG_W-1:0] v);
		logic [CW-1:0] e;
		e = CW'(v);
		if (e > TMAX) begin
			e = TMAX;
		end
		return TIMER_BITS'(e);
	endfunction

	assign load_t3    = cap(t3_ticks_q);
	assign load_act   = cap(act_delay_q);
	assign load_deact = cap(deact_delay_q);

	assign advance   = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t3_ticks_q    <= T3_TICKS_RST;
			act_delay_q   <= ACT_DELAY_RST;
			deact_delay_q <= DEACT_DELAY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_T3_TICKS:    t3_ticks_q    <= cfg_data;
				CFG_ACT_DELAY:   act_delay_q   <= cfg_data;
				CFG_DEACT_DELAY: deact_delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tdata[3:0];
			frame_s1  <= s_tdata[4];
			busy_s1   <= s_tdata[5];
		end
	end

	always_comb begin
		in_range = (state_q >= ST_F3) && (state_q <= ST_F8);
		early    = (action_s1 == EV_TICK) && frame_s1 && flags_q.act_timer;
		fire     = (action_s1 == EV_TICK) && !early && pending_q && (count_q <= TONE);
		act_ok   = (early || (fire && kind_q == TK_ACT)) && (state_q == ST_F7);
		t3_ok    = fire && (kind_q == TK_T3) && (state_q != ST_F7);
		deact_ok = fire && (kind_q == TK_DEACT) && in_range;
	end

	// Next state, flags and timer.
	always_comb begin
		state_d   = state_q;
		flags_d   = flags_q;
		count_d   = count_q;
		pending_d = pending_q;
		kind_d    = kind_q;
		case (action_s1)
			EV_TICK: begin
				if (early) begin
					if (pending_q && kind_q == TK_ACT) begin
						pending_d = 1'b0;
					end
				end else if (pending_q) begin
					if (count_q > TONE) begin
						count_d = count_q - TONE;
					end else begin
						count_d   = '0;
						pending_d = 1'b0;
					end
				end
				if (act_ok) begin
					flags_d.act_timer  = 1'b0;
					flags_d.activated  = 1'b1;
					flags_d.activating = 1'b0;
				end
				if (t3_ok) begin
					flags_d.t3_running = 1'b0;
					flags_d.activating = 1'b0;
					if (state_q != ST_F6) begin
						state_d = ST_F3;
					end
				end
				if (deact_ok) begin
					flags_d.deact_timer = 1'b0;
					flags_d.activated   = 1'b0;
				end
			end
			EV_ACTIVATE: begin
				if (!flags_q.activated) begin
					flags_d.activating = !((state_q == ST_F6 || state_q == ST_F8) &&
						!flags_q.deact_timer && !flags_q.t3_running);
				end
			end
			EV_LINE_RESET, EV_DEACT_DONE: begin
				if (in_range) begin
					state_d = ST_F3;
				end
			end
			EV_LINE_DEACT: begin
				if (state_q == ST_F6 || state_q == ST_F7 || state_q == ST_F8) begin
					state_d             = ST_F3;
					count_d             = load_deact;
					pending_d           = 1'b1;
					kind_d              = TK_DEACT;
					flags_d.deact_timer = 1'b1;
				end
			end
			EV_POWERUP: begin
				if (state_q == ST_F3 && flags_q.activating) begin
					state_d            = ST_F4;
					count_d            = load_t3;
					pending_d          = 1'b1;
					kind_d             = TK_T3;
					flags_d.t3_running = 1'b1;
				end
			end
			EV_RSYNC: begin
				if (state_q == ST_F4) begin
					state_d = ST_F5;
				end else if (state_q == ST_F6 || state_q == ST_F7) begin
					state_d = ST_F8;
				end
			end
			EV_INFO2: begin
				if (in_range && state_q != ST_F6) begin
					state_d = ST_F6;
				end
			end
			EV_INFO4: begin
				if (in_range && state_q != ST_F7) begin
					state_d = ST_F7;
					if (flags_q.deact_timer) begin
						flags_d.deact_timer = 1'b0;
						pending_d           = 1'b0;
					end
					if (!flags_q.activated) begin
						flags_d.t3_running = 1'b0;
						count_d            = load_act;
						pending_d          = 1'b1;
						kind_d             = TK_ACT;
						flags_d.act_timer  = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Requests and messages of this event.
	always_comb begin
		hw_d    = HW_NONE;
		up_d    = UP_NONE;
		pause_d = 1'b0;
		case (action_s1)
			EV_TICK: begin
				if (act_ok) begin
					up_d = flags_q.activating ? UP_ACT_CNF : UP_ACT_IND;
				end
				if (t3_ok) begin
					if (flags_q.activating) begin
						up_d    = UP_DEACT_IND;
						pause_d = busy_s1;
					end
					if (state_q != ST_F6) begin
						hw_d = HW_ENABLE_REQ;
					end
				end
				if (deact_ok) begin
					up_d    = UP_DEACT_IND;
					pause_d = busy_s1;
					hw_d    = HW_DEACT_RSP;
				end
			end
			EV_ACTIVATE: begin
				if (flags_q.activated) begin
					up_d = UP_ACT_CNF;
				end else if (state_q == ST_F3) begin
					hw_d = HW_RESET_REQ;
				end else if ((state_q == ST_F6 || state_q == ST_F8) &&
					!flags_q.deact_timer && !flags_q.t3_running) begin
					up_d    = UP_DEACT_IND;
					pause_d = busy_s1;
				end
			end
			EV_DEACT_DONE: begin
				if (in_range && flags_q.activating) begin
					hw_d = HW_ENABLE_REQ;
				end
			end
			EV_POWERUP: begin
				if (state_q == ST_F3 && flags_q.activating) begin
					hw_d = HW_INFO3_REQ;
				end
			end
			EV_INFO2: begin
				if (in_range && state_q != ST_F6) begin
					hw_d = HW_INFO3_REQ;
				end
			end
			EV_INFO4: begin
				if (in_range && state_q != ST_F7) begin
					hw_d = HW_INFO3_REQ;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_F3;
			flags_q   <= '0;
			count_q   <= '0;
			pending_q <= 1'b0;
			kind_q    <= TK_NONE;
		end else if (advance) begin
			state_q   <= state_d;
			flags_q   <= flags_d;
			count_q   <= count_d;
			pending_q <= pending_d;
			kind_q    <= kind_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {6'd0, flags_d.activated, pause_d, up_d, hw_d, state_d};
		end
	end

	a_never_f2: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_F2)
		else $error("line state entered F2");

	a_pending_kind: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> kind_q != TK_NONE)
		else $error("timer pending without a kind");

	a_pause_with_deact: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tdata[7:6] == UP_DEACT_IND)
		else $error("pause confirm without deactivate indication");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("processed event produced no result");

	a_idle_timer_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 == EV_TICK && !pending_q |=> $stable(count_q))
		else $error("stopped timer changed on a tick");

endmodule
